// ===== rtl/kha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kha_pkg: shared definitions for the key hold auto-repeat core
// Widths, register reset values and register index codes.
// ----------------------------------------------------------------------------
package kha_pkg;

   localparam int CountWidth    = 16;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 2;
   localparam int KindWidth     = 4;
   localparam int KeyWidth      = 3;
   localparam int RowWidth      = 4;
   localparam int ColWidth      = 5;

   localparam logic [CountWidth-1:0] CountMax = '1;

   localparam logic [CsrDataWidth-1:0] RepeatDelayReset  = 16'd300;
   localparam logic [CsrDataWidth-1:0] FastAfterReset    = 16'd1000;
   localparam logic [CsrDataWidth-1:0] SlowIntervalReset = 16'd80;
   localparam logic [CsrDataWidth-1:0] FastIntervalReset = 16'd20;

   // Request kinds.
   localparam logic FuncKeyEvent = 1'b0;
   localparam logic FuncTick     = 1'b1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_REPEAT_DELAY  = 2'd0,
      CSR_FAST_AFTER    = 2'd1,
      CSR_SLOW_INTERVAL = 2'd2,
      CSR_FAST_INTERVAL = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/kha_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kha_req_if: request channel of the key hold auto-repeat core
// Valid/ready handshake carrying one key event or one millisecond tick.
// ----------------------------------------------------------------------------
interface kha_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic                         pressed;
   logic [kha_pkg::KindWidth-1:0] key_kind;
   logic [kha_pkg::RowWidth-1:0]  key_row;
   logic [kha_pkg::ColWidth-1:0]  key_col;
   logic                         held_down;

   modport source (
      output valid, func, pressed, key_kind, key_row, key_col, held_down,
      input  ready
   );

   modport sink (
      input  valid, func, pressed, key_kind, key_row, key_col, held_down,
      output ready
   );
endinterface

// ===== rtl/kha_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kha_rsp_if: result channel of the key hold auto-repeat core
// Valid/ready handshake carrying the step pulse and the hold status.
// ----------------------------------------------------------------------------
interface kha_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        step_valid;
   logic [kha_pkg::KeyWidth-1:0] step_key;
   logic                        armed;
   logic [kha_pkg::RowWidth-1:0] held_row;
   logic [kha_pkg::ColWidth-1:0] held_col;

   modport source (
      output valid, step_valid, step_key, armed, held_row, held_col,
      input  ready
   );

   modport sink (
      input  valid, step_valid, step_key, armed, held_row, held_col,
      output ready
   );
endinterface

// ===== rtl/key_hold_auto_repeat_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hold_auto_repeat_core: two-rate hold-to-repeat generator
// Turns a held adjust key into a stream of slow, then fast, step pulses.
// ----------------------------------------------------------------------------
// Every request (key event or one millisecond tick) produces exactly one
// result, in the cycle after the request is taken, and a new request can
// be taken in every cycle as long as the result register is empty or being
// drained in the same cycle. The whole update of the hold state is one short
// path of saturating counters and compares that ends in the state registers
// and the result register. Write the four timing registers through the csr
// port only while no request is in flight; the core does not enforce this. The
// fast threshold is a precomputed 17-bit sum so the tick path needs no adder.
module key_hold_auto_repeat_core (
   input  logic                              clock,
   input  logic                              reset,
   kha_req_if.sink                           req_bus,
   kha_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [kha_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [kha_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import kha_pkg::*;

   // Timing registers.
   logic [CsrDataWidth-1:0] repeat_delay_ff, repeat_delay_in;
   logic [CsrDataWidth-1:0] fast_after_ff, fast_after_in;
   logic [CsrDataWidth-1:0] slow_interval_ff, slow_interval_in;
   logic [CsrDataWidth-1:0] fast_interval_ff, fast_interval_in;
   logic [CsrDataWidth:0]   fast_thr_ff, fast_thr_in;

   // Hold state.
   logic                  armed_ff, armed_in;
   logic [KeyWidth-1:0]   held_key_ff, held_key_in;
   logic [RowWidth-1:0]   pos_row_ff, pos_row_in;
   logic [ColWidth-1:0]   pos_col_ff, pos_col_in;
   logic [CountWidth-1:0] since_press_ff, since_press_in;
   logic [CountWidth-1:0] since_step_ff, since_step_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                step_valid_ff, step_valid_in;
   logic [KeyWidth-1:0] step_key_ff, step_key_in;

   logic                  req_take;
   logic                  is_adjust;
   logic [CountWidth-1:0] press_inc;
   logic [CountWidth-1:0] step_inc;
   logic [CountWidth-1:0] interval;
   csr_index_type         csr_sel;

   // The result register frees up when it is empty or drained this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign csr_sel = csr_index_type'(csr_index);

   // Register writes; the fast threshold follows the new values directly.
   always_comb begin
      repeat_delay_in  = repeat_delay_ff;
      fast_after_in    = fast_after_ff;
      slow_interval_in = slow_interval_ff;
      fast_interval_in = fast_interval_ff;
      if (csr_we) begin
         case (csr_sel)
            CSR_REPEAT_DELAY:  repeat_delay_in  = csr_wdata;
            CSR_FAST_AFTER:    fast_after_in    = csr_wdata;
            CSR_SLOW_INTERVAL: slow_interval_in = csr_wdata;
            CSR_FAST_INTERVAL: fast_interval_in = csr_wdata;
            default:           repeat_delay_in  = repeat_delay_ff;
         endcase
      end
      fast_thr_in = {1'b0, repeat_delay_in} + {1'b0, fast_after_in};
   end

   // Kinds 8 through 15 all count as non-adjust keys.
   assign is_adjust = !req_bus.key_kind[KindWidth-1];

   assign press_inc = (since_press_ff == CountMax) ? CountMax : since_press_ff + 1'b1;
   assign step_inc  = (since_step_ff == CountMax) ? CountMax : since_step_ff + 1'b1;

   // The hold is past the fast threshold only when the sum fits in 16 bits.
   assign interval = ({1'b0, press_inc} > fast_thr_ff) ? fast_interval_ff
                                                       : slow_interval_ff;

   always_comb begin
      armed_in       = armed_ff;
      held_key_in    = held_key_ff;
      pos_row_in     = pos_row_ff;
      pos_col_in     = pos_col_ff;
      since_press_in = since_press_ff;
      since_step_in  = since_step_ff;
      step_valid_in  = 1'b0;
      step_key_in    = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      if (req_take) begin
         rsp_valid_in = 1'b1;
         if (req_bus.func == FuncKeyEvent) begin
            if (is_adjust) begin
               if (req_bus.pressed) begin
                  armed_in       = 1'b1;
                  held_key_in    = req_bus.key_kind[KeyWidth-1:0];
                  pos_row_in     = req_bus.key_row;
                  pos_col_in     = req_bus.key_col;
                  since_press_in = '0;
                  since_step_in  = '0;
               end else if (armed_ff &&
                            req_bus.key_kind[KeyWidth-1:0] == held_key_ff) begin
                  // Release of the held key; the position is not compared.
                  armed_in = 1'b0;
               end
            end else if (req_bus.pressed) begin
               armed_in = 1'b0;
            end
         end else if (armed_ff) begin
            if (!req_bus.held_down) begin
               armed_in = 1'b0;
            end else begin
               since_press_in = press_inc;
               since_step_in  = step_inc;
               if (press_inc >= repeat_delay_ff && step_inc >= interval) begin
                  since_step_in = '0;
                  step_valid_in = 1'b1;
                  step_key_in   = held_key_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff  <= RepeatDelayReset;
         fast_after_ff    <= FastAfterReset;
         slow_interval_ff <= SlowIntervalReset;
         fast_interval_ff <= FastIntervalReset;
         fast_thr_ff      <= {1'b0, RepeatDelayReset} + {1'b0, FastAfterReset};
         armed_ff         <= 1'b0;
         held_key_ff      <= '0;
         pos_row_ff       <= '0;
         pos_col_ff       <= '0;
         since_press_ff   <= '0;
         since_step_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         repeat_delay_ff  <= repeat_delay_in;
         fast_after_ff    <= fast_after_in;
         slow_interval_ff <= slow_interval_in;
         fast_interval_ff <= fast_interval_in;
         fast_thr_ff      <= fast_thr_in;
         armed_ff         <= armed_in;
         held_key_ff      <= held_key_in;
         pos_row_ff       <= pos_row_in;
         pos_col_ff       <= pos_col_in;
         since_press_ff   <= since_press_in;
         since_step_ff    <= since_step_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload loads only when a request is taken.
   always_ff @(posedge clock) begin
      if (req_take) begin
         step_valid_ff <= step_valid_in;
         step_key_ff   <= step_key_in;
      end
   end

   // The hold status in a result is the state after its request, which the
   // state registers keep until the next request is taken.
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.step_valid = step_valid_ff;
   assign rsp_bus.step_key   = step_key_ff;
   assign rsp_bus.armed      = armed_ff;
   assign rsp_bus.held_row   = pos_row_ff;
   assign rsp_bus.held_col   = pos_col_ff;

endmodule

// ===== rtl/kha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kha_checker: port-level checks for the key hold auto-repeat core
// Watches the request and result channels and the result payload.
// ----------------------------------------------------------------------------
module kha_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_func,
   input logic                         req_pressed,
   input logic [kha_pkg::KindWidth-1:0] req_key_kind,
   input logic [kha_pkg::RowWidth-1:0]  req_key_row,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_step_valid,
   input logic [kha_pkg::KeyWidth-1:0]  rsp_step_key,
   input logic                         rsp_armed,
   input logic [kha_pkg::RowWidth-1:0]  rsp_held_row
);
   import kha_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_step_needs_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_valid |-> rsp_armed)
      else $error("step pulse without an armed hold");

   a_no_step_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_step_valid |-> rsp_step_key == '0)
      else $error("step key set without a step");

   a_press_arms: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FuncKeyEvent && req_pressed &&
      !req_key_kind[KindWidth-1]
      |=> rsp_valid && rsp_armed && !rsp_step_valid &&
          rsp_held_row == $past(req_key_row))
      else $error("adjust press did not arm the hold");

endmodule

bind key_hold_auto_repeat_core kha_checker u_kha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_func       (req_bus.func),
   .req_pressed    (req_bus.pressed),
   .req_key_kind   (req_bus.key_kind),
   .req_key_row    (req_bus.key_row),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_step_valid (rsp_bus.step_valid),
   .rsp_step_key   (rsp_bus.step_key),
   .rsp_armed      (rsp_bus.armed),
   .rsp_held_row   (rsp_bus.held_row)
);
